// ===== hw/rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared codes and widths for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PHASE_W = 4;
   localparam int unsigned BITS_W  = 4;

   // operation codes on the request channel
   localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_W-1:0] OP_START = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;

   // sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE        = 4'd0;
   localparam logic [PHASE_W-1:0] PH_ST_SDA_LOW  = 4'd1;
   localparam logic [PHASE_W-1:0] PH_ST_SCL_LOW  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_FINISH      = 4'd3;
   localparam logic [PHASE_W-1:0] PH_SP_SCL_HIGH = 4'd4;
   localparam logic [PHASE_W-1:0] PH_SP_SDA_HIGH = 4'd5;
   localparam logic [PHASE_W-1:0] PH_WR_SCL_LOW  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_WR_NEXT     = 4'd7;
   localparam logic [PHASE_W-1:0] PH_WR_ACK      = 4'd8;
   localparam logic [PHASE_W-1:0] PH_RD_SAMPLE   = 4'd9;
   localparam logic [PHASE_W-1:0] PH_RD_NEXT     = 4'd10;
   localparam logic [PHASE_W-1:0] PH_RD_ACK_LOW  = 4'd11;

   localparam logic [BYTE_W-1:0] HALF_PERIOD_RESET = 8'd8;
   localparam logic [BITS_W-1:0] BITS_PER_BYTE     = 4'd8;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// Bit-banged I2C master: start, stop, write byte and read byte sequences.
// ----------------------------------------------------------------------------
// Usage:
//   - req channel carries one transfer per tick or command. While idle a
//     start, stop, write or read command opens a sequence; while busy only
//     tick transfers advance it, other codes are dropped (still answered).
//   - every accepted req transfer yields exactly one rsp transfer holding
//     the SCL/SDA drive levels, busy/done flags, last read byte and the
//     no-ack flag of the last write, all as they stand after that transfer.
//   - each bus phase lasts csr_write_data ticks (0 acts as 1); the user must
//     write the register via csr_write_enable only while no sequence is
//     running (not enforced); rsp is valid in the cycle after req acceptance.
//   - throughput: one transfer per cycle unless rsp stalls; the whole update
//     is one pass of logic from the state registers into the same registers.
//   - the rsp side is a single output register; req_ready stays high as
//     long as that register is empty or being drained in the same cycle,
//     so a stalled receiver holds off the requester after one transfer.
//   - reset: idle, SCL high, SDA driven high, counters and read byte zero,
//     half period back to 8 ticks, no rsp transfer pending.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_sequencer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [i2cms_pkg::OP_W-1:0]     req_operation,
   input  wire logic [i2cms_pkg::BYTE_W-1:0]   req_write_data,
   input  wire logic                           req_send_ack,
   input  wire logic                           req_sda_sample,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_scl_level,
   output      logic                           rsp_sda_level,
   output      logic                           rsp_sda_drive,
   output      logic                           rsp_busy_res,
   output      logic                           rsp_done_res,
   output      logic [i2cms_pkg::BYTE_W-1:0]   rsp_read_data,
   output      logic                           rsp_no_ack,
   input  wire logic                           csr_write_enable,
   input  wire logic [i2cms_pkg::BYTE_W-1:0]   csr_write_data
);
   import i2cms_pkg::*;

   // sequencer state
   logic [PHASE_W-1:0] phase_ff,      phase_in;
   logic [BITS_W-1:0]  bit_count_ff,  bit_count_in;
   logic [BYTE_W-1:0]  tick_count_ff, tick_count_in;
   logic [BYTE_W-1:0]  shift_byte_ff, shift_byte_in;
   logic               ack_choice_ff, ack_choice_in;
   logic               ack_missing_ff, ack_missing_in;
   logic               scl_ff,        scl_in;
   logic               sda_ff,        sda_in;
   logic               drive_ff,      drive_in;
   logic [BYTE_W-1:0]  last_read_ff,  last_read_in;
   logic               done_ff,       done_in;

   // output register occupancy and config
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [BYTE_W-1:0]  half_ff;

   logic               req_fire;
   logic [BYTE_W-1:0]  half_eff;
   logic [BYTE_W-1:0]  tick_dec;
   logic [BITS_W-1:0]  bit_next;

   // output register can take a new result when empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // zero half period counts as one tick
   assign half_eff = (half_ff == '0) ? BYTE_W'(1) : half_ff;
   assign tick_dec = tick_count_ff - BYTE_W'(1);
   assign bit_next = bit_count_ff + BITS_W'(1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // one pass of the sequencer per accepted transfer
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      tick_count_in  = tick_count_ff;
      shift_byte_in  = shift_byte_ff;
      ack_choice_in  = ack_choice_ff;
      ack_missing_in = ack_missing_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      drive_in       = drive_ff;
      last_read_in   = last_read_ff;
      done_in        = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // launch a new command sequence
         case (req_operation)
            OP_START: begin
               bit_count_in  = '0;
               scl_in        = 1'b1;
               drive_in      = 1'b1;
               sda_in        = 1'b1;
               phase_in      = PH_ST_SDA_LOW;
               tick_count_in = half_eff;
            end
            OP_STOP: begin
               bit_count_in  = '0;
               drive_in      = 1'b1;
               sda_in        = 1'b0;
               phase_in      = PH_SP_SCL_HIGH;
               tick_count_in = half_eff;
            end
            OP_WRITE: begin
               bit_count_in  = '0;
               drive_in      = 1'b1;
               sda_in        = req_write_data[BYTE_W-1];
               shift_byte_in = {req_write_data[BYTE_W-2:0], 1'b0};
               scl_in        = 1'b1;
               phase_in      = PH_WR_SCL_LOW;
               tick_count_in = half_eff;
            end
            OP_READ: begin
               bit_count_in  = '0;
               ack_choice_in = req_send_ack;
               shift_byte_in = '0;
               drive_in      = 1'b0;
               sda_in        = 1'b1;
               scl_in        = 1'b1;
               phase_in      = PH_RD_SAMPLE;
               tick_count_in = half_eff;
            end
            default: begin
            end
         endcase
      end else if (req_operation == OP_TICK) begin
         tick_count_in = tick_dec;
         if (tick_dec == '0) begin
            // wait ran out: take the next bus action
            tick_count_in = half_eff;
            case (phase_ff)
               PH_ST_SDA_LOW: begin
                  drive_in = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = PH_ST_SCL_LOW;
               end
               PH_ST_SCL_LOW: begin
                  scl_in   = 1'b0;
                  phase_in = PH_FINISH;
               end
               PH_SP_SCL_HIGH: begin
                  scl_in   = 1'b1;
                  phase_in = PH_SP_SDA_HIGH;
               end
               PH_SP_SDA_HIGH: begin
                  drive_in = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_FINISH;
               end
               PH_WR_SCL_LOW: begin
                  scl_in   = 1'b0;
                  phase_in = PH_WR_NEXT;
               end
               PH_WR_NEXT: begin
                  bit_count_in = bit_next;
                  scl_in       = 1'b1;
                  if (bit_next < BITS_PER_BYTE) begin
                     drive_in      = 1'b1;
                     sda_in        = shift_byte_ff[BYTE_W-1];
                     shift_byte_in = {shift_byte_ff[BYTE_W-2:0], 1'b0};
                     phase_in      = PH_WR_SCL_LOW;
                  end else begin
                     // release SDA for the slave acknowledge
                     drive_in = 1'b0;
                     sda_in   = 1'b1;
                     phase_in = PH_WR_ACK;
                  end
               end
               PH_WR_ACK: begin
                  ack_missing_in = req_sda_sample;
                  scl_in         = 1'b0;
                  phase_in       = PH_FINISH;
               end
               PH_RD_SAMPLE: begin
                  shift_byte_in = {shift_byte_ff[BYTE_W-2:0], req_sda_sample};
                  scl_in        = 1'b0;
                  phase_in      = PH_RD_NEXT;
               end
               PH_RD_NEXT: begin
                  bit_count_in = bit_next;
                  scl_in       = 1'b1;
                  if (bit_next < BITS_PER_BYTE) begin
                     phase_in = PH_RD_SAMPLE;
                  end else begin
                     // byte complete, drive ack (low) or no-ack (high)
                     last_read_in = shift_byte_ff;
                     drive_in     = 1'b1;
                     sda_in       = !ack_choice_ff;
                     phase_in     = PH_RD_ACK_LOW;
                  end
               end
               PH_RD_ACK_LOW: begin
                  scl_in   = 1'b0;
                  phase_in = PH_FINISH;
               end
               default: begin
                  // finish phase and unused codes close the sequence
                  phase_in      = PH_IDLE;
                  tick_count_in = '0;
                  done_in       = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         tick_count_ff  <= '0;
         shift_byte_ff  <= '0;
         ack_choice_ff  <= 1'b0;
         ack_missing_ff <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         drive_ff       <= 1'b1;
         last_read_ff   <= '0;
         done_ff        <= 1'b0;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         tick_count_ff  <= tick_count_in;
         shift_byte_ff  <= shift_byte_in;
         ack_choice_ff  <= ack_choice_in;
         ack_missing_ff <= ack_missing_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         drive_ff       <= drive_in;
         last_read_ff   <= last_read_in;
         done_ff        <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= HALF_PERIOD_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            half_ff <= csr_write_data;
         end
      end
   end

   // result fields are the state left by the last accepted transfer
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_sda_drive = drive_ff;
   assign rsp_busy_res  = (phase_ff != PH_IDLE);
   assign rsp_done_res  = done_ff;
   assign rsp_read_data = last_read_ff;
   assign rsp_no_ack    = ack_missing_ff;

   // a finished sequence is never reported as busy
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (phase_ff == PH_IDLE))
      else $error("done flagged while sequence still busy");

   // idle means no wait pending, busy means a wait is loaded
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == (tick_count_ff == '0))
      else $error("tick counter out of step with phase");

   // a released SDA line always reads back as high level
   assert property (@(posedge clock) disable iff (reset)
      !drive_ff |-> sda_ff)
      else $error("sda low while released");

   // every accepted request produces a pending result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transfer produced no result");

   // bit counter never runs past one byte
   assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BITS_PER_BYTE)
      else $error("bit counter overflow");

endmodule

`default_nettype wire
